// ===== rtl/ps2_mouse_packet_tracker_unit_defines.svh =====
// Assertion macros for the mouse packet tracker checkers.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PS2MPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PS2MPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ps2mpt_pkg.sv =====
// Shared types and constants for the mouse packet tracker.
// No dependencies.
`default_nettype none

package ps2mpt_pkg;

  localparam int POS_BITS = 12;
  localparam int CFG_BITS = 13;
  localparam int OUT_BITS = 12;
  localparam int CALC_W   = (POS_BITS + 1 > CFG_BITS) ? POS_BITS + 1 : CFG_BITS;

  localparam logic [CFG_BITS-1:0] WIDTH_RST  = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] HEIGHT_RST = CFG_BITS'(768);

  typedef enum logic [1:0] {
    PH_STATUS = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_RIGHT = 2'd1;
  localparam logic [1:0] EV_LEFT  = 2'd2;

  typedef struct packed {
    phase_t              phase;
    logic [7:0]          status;
    logic [7:0]          x_delta;
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
  } trk_state_t;

  typedef struct packed {
    logic                has_result;
    logic [OUT_BITS-1:0] cursor_x;
    logic [OUT_BITS-1:0] cursor_y;
    logic [1:0]          button_event;
    logic                packet_dropped;
  } trk_result_t;

endpackage

`default_nettype wire

// ===== rtl/ps2mpt_ifs.sv =====
// Valid/ready channel interfaces for the mouse packet tracker.
// No dependencies.
`default_nettype none

interface ps2mpt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_aux;
  modport source (output valid, output data_byte, output is_aux, input ready);
  modport sink (input valid, input data_byte, input is_aux, output ready);
endinterface

interface ps2mpt_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [1:0]  button_event;
  logic        packet_dropped;
  modport source (output valid, output cursor_x, output cursor_y,
                  output button_event, output packet_dropped, input ready);
  modport sink (input valid, input cursor_x, input cursor_y,
                input button_event, input packet_dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/ps2mpt_step.sv =====
// Packet framing and cursor update for one registered byte.
// Depends on ps2mpt_pkg.
`default_nettype none

module ps2mpt_step
  import ps2mpt_pkg::*;
(
  input  trk_state_t          state_cur,
  input  logic [7:0]          data_byte,
  input  logic                is_aux,
  input  logic [CFG_BITS-1:0] screen_width,
  input  logic [CFG_BITS-1:0] screen_height,
  output trk_state_t          state_nxt,
  output trk_result_t         result
);

  function automatic logic [POS_BITS-1:0] move_pos(
    input logic [POS_BITS-1:0] pos,
    input logic [8:0]          mag,
    input logic                up,
    input logic [CFG_BITS-1:0] bound
  );
    logic [CALC_W-1:0] lim;
    logic [CALC_W-1:0] sum;
    logic [CALC_W-1:0] top;
    top = CALC_W'(1) << POS_BITS;
    lim = CALC_W'(bound);
    if (lim == '0) begin
      lim = CALC_W'(1);
    end else if (lim > top) begin
      lim = top;
    end
    if (up) begin
      sum = CALC_W'(pos) + CALC_W'(mag);
      if (sum >= lim) begin
        sum = lim - CALC_W'(1);
      end
      return POS_BITS'(sum);
    end
    if (CALC_W'(mag) > CALC_W'(pos)) begin
      return '0;
    end
    sum = CALC_W'(pos) - CALC_W'(mag);
    return POS_BITS'(sum);
  endfunction

  logic [7:0] st;
  logic [7:0] xb;
  logic [8:0] x_mag;
  logic [8:0] y_mag;

  assign st    = state_cur.status;
  assign xb    = state_cur.x_delta;
  assign x_mag = st[4] ? (9'd256 - {1'b0, xb}) : {1'b0, xb};
  assign y_mag = st[5] ? (9'd256 - {1'b0, data_byte}) : {1'b0, data_byte};

  always_comb begin
    state_nxt             = state_cur;
    result.has_result     = 1'b0;
    result.button_event   = EV_NONE;
    result.packet_dropped = 1'b0;
    if (is_aux) begin
      case (state_cur.phase)
        PH_STATUS: begin
          state_nxt.status = data_byte;
          state_nxt.phase  = PH_XDELTA;
        end
        PH_XDELTA: begin
          state_nxt.x_delta = data_byte;
          state_nxt.phase   = PH_YDELTA;
        end
        PH_YDELTA: begin
          state_nxt.phase   = PH_STATUS;
          result.has_result = 1'b1;
          if (st[7:6] != 2'b00) begin
            result.packet_dropped = 1'b1;
          end else begin
            if (xb != 8'd0 || data_byte != 8'd0) begin
              state_nxt.pos_x = move_pos(state_cur.pos_x, x_mag, !st[4], screen_width);
              state_nxt.pos_y = move_pos(state_cur.pos_y, y_mag, st[5], screen_height);
            end
            if (st[1]) begin
              result.button_event = EV_RIGHT;
            end else if (st[0]) begin
              result.button_event = EV_LEFT;
            end
          end
        end
        default: begin
          state_nxt.phase = PH_STATUS;
        end
      endcase
    end
    result.cursor_x = OUT_BITS'(state_nxt.pos_x);
    result.cursor_y = OUT_BITS'(state_nxt.pos_y);
  end

endmodule

`default_nettype wire

// ===== rtl/ps2_mouse_packet_tracker_unit.sv =====
// Mouse packet tracker top level: input register, packet step, result register.
// A packet's last byte sits in the input register until its result can be registered.
// Throughput: one byte per cycle unless a result stalls; the step clamps each axis.
// Reset (rst_n low, synchronous): skip first mouse byte, cursor at 0, bounds 1024x768.
// Depends on ps2mpt_pkg, ps2mpt_ifs, ps2mpt_step.
`default_nettype none

module ps2_mouse_packet_tracker_unit
  import ps2mpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ps2mpt_in_if.sink           in_ch,
  ps2mpt_out_if.source        out_ch,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                in_aux_r;
  trk_state_t          state_r;
  trk_state_t          state_nxt;
  trk_result_t         result;
  logic [CFG_BITS-1:0] width_r;
  logic [CFG_BITS-1:0] height_r;
  logic                out_vld_r;
  logic [OUT_BITS-1:0] out_x_r;
  logic [OUT_BITS-1:0] out_y_r;
  logic [1:0]          out_ev_r;
  logic                out_drop_r;
  logic                out_free;
  logic                advance;
  logic                in_take;

  ps2mpt_step u_step (
    .state_cur     (state_r),
    .data_byte     (in_byte_r),
    .is_aux        (in_aux_r),
    .screen_width  (width_r),
    .screen_height (height_r),
    .state_nxt     (state_nxt),
    .result        (result)
  );

  assign out_free    = !out_vld_r || out_ch.ready;
  assign advance     = in_vld_r && (!result.has_result || out_free);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_vld_r;
  assign out_ch.cursor_x       = out_x_r;
  assign out_ch.cursor_y       = out_y_r;
  assign out_ch.button_event   = out_ev_r;
  assign out_ch.packet_dropped = out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      state_r.phase <= PH_SKIP;
      state_r.pos_x <= '0;
      state_r.pos_y <= '0;
      width_r       <= WIDTH_RST;
      height_r      <= HEIGHT_RST;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && result.has_result) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_WIDTH:  width_r  <= cfg_data;
          CFG_IDX_HEIGHT: height_r <= cfg_data;
          default:        width_r  <= width_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.data_byte;
      in_aux_r  <= in_ch.is_aux;
    end
    if (advance && result.has_result) begin
      out_x_r    <= result.cursor_x;
      out_y_r    <= result.cursor_y;
      out_ev_r   <= result.button_event;
      out_drop_r <= result.packet_dropped;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ps2mpt_checker.sv =====
// Port-level checks for the mouse packet tracker, bound to the top level.
// Depends on ps2mpt_pkg and ps2_mouse_packet_tracker_unit_defines.svh.
`default_nettype none
`include "ps2_mouse_packet_tracker_unit_defines.svh"

module ps2mpt_checker
  import ps2mpt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] cursor_x,
  input logic [OUT_BITS-1:0] cursor_y,
  input logic [1:0]          button_event,
  input logic                packet_dropped
);

  `PS2MPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result lost while stalled")
  `PS2MPT_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(cursor_x) && $stable(cursor_y) && $stable(button_event) && $stable(packet_dropped), "stalled result changed")
  `PS2MPT_ASSERT_IMP(a_event_code, out_valid, button_event != 2'd3, "invalid button event")
  `PS2MPT_ASSERT_IMP(a_drop_no_event, out_valid && packet_dropped, button_event == EV_NONE, "dropped packet reports event")

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker u_ps2mpt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .cursor_x       (out_ch.cursor_x),
  .cursor_y       (out_ch.cursor_y),
  .button_event   (out_ch.button_event),
  .packet_dropped (out_ch.packet_dropped)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for ps2_mouse_packet_tracker_unit: byte framing, cursor clamping, button events.
// Uses ps2mpt_pkg and the channel interfaces in ps2mpt_ifs; checks every result
// against an in-bench tracker model, also under random sender gaps and receiver stalls.

module tb_top;
  import ps2mpt_pkg::*;

  localparam logic [7:0] BTN_LEFT  = 8'h01;
  localparam logic [7:0] BTN_RIGHT = 8'h02;
  localparam logic [7:0] X_NEG     = 8'h10;
  localparam logic [7:0] Y_NEG     = 8'h20;
  localparam logic [7:0] X_OVF     = 8'h40;
  localparam logic [7:0] Y_OVF     = 8'h80;

  localparam int RCV_ALWAYS  = 0;
  localparam int RCV_RANDOM  = 1;
  localparam int RCV_PATTERN = 2;
  localparam int RCV_SPARSE  = 3;
  localparam logic [6:0] RCV_MASK = 7'b1101001;

  typedef struct {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic [1:0]          ev;
    logic                drop;
  } cursor_rpt_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  ps2mpt_in_if  in_ch ();
  ps2mpt_out_if out_ch ();

  ps2_mouse_packet_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  phase_t              trk_phase  = PH_SKIP;
  logic [7:0]          trk_status = '0;
  logic [7:0]          trk_xdelta = '0;
  logic [POS_BITS-1:0] trk_x      = '0;
  logic [POS_BITS-1:0] trk_y      = '0;
  logic [CFG_BITS-1:0] bound_w    = WIDTH_RST;
  logic [CFG_BITS-1:0] bound_h    = HEIGHT_RST;

  cursor_rpt_t expected_moves[$];
  int          err_count = 0;

  int          burst_left = 0;
  int          gap_max = 0;
  int          rcv_mode = RCV_ALWAYS;
  int unsigned rcv_tick = 0;
  int          hold_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [POS_BITS-1:0] step_axis(logic [POS_BITS-1:0] pos,
                                                    int unsigned mag, bit up,
                                                    logic [CFG_BITS-1:0] bound);
    int unsigned lim;
    int unsigned n;
    lim = (bound == 0) ? 1 : ((bound > (1 << POS_BITS)) ? (1 << POS_BITS) : bound);
    if (up) begin
      n = pos + mag;
      if (n >= lim) n = lim - 1;
      return POS_BITS'(n);
    end
    if (mag > pos) return '0;
    return POS_BITS'(pos - mag);
  endfunction

  function automatic void track_byte(logic [7:0] b, logic aux);
    cursor_rpt_t rpt;
    if (!aux) return;
    case (trk_phase)
      PH_SKIP:   trk_phase = PH_STATUS;
      PH_STATUS: begin
        trk_status = b;
        trk_phase  = PH_XDELTA;
      end
      PH_XDELTA: begin
        trk_xdelta = b;
        trk_phase  = PH_YDELTA;
      end
      default: begin
        trk_phase = PH_STATUS;
        rpt.ev    = EV_NONE;
        rpt.drop  = 1'b0;
        if ((trk_status & (X_OVF | Y_OVF)) != 0) begin
          rpt.drop = 1'b1;
        end else begin
          if (trk_xdelta != 0 || b != 0) begin
            if ((trk_status & X_NEG) != 0)
              trk_x = step_axis(trk_x, 256 - trk_xdelta, 1'b0, bound_w);
            else
              trk_x = step_axis(trk_x, trk_xdelta, 1'b1, bound_w);
            if ((trk_status & Y_NEG) != 0)
              trk_y = step_axis(trk_y, 256 - b, 1'b1, bound_h);
            else
              trk_y = step_axis(trk_y, b, 1'b0, bound_h);
          end
          if ((trk_status & BTN_RIGHT) != 0) rpt.ev = EV_RIGHT;
          else if ((trk_status & BTN_LEFT) != 0) rpt.ev = EV_LEFT;
        end
        rpt.x = trk_x;
        rpt.y = trk_y;
        expected_moves.push_back(rpt);
      end
    endcase
  endfunction

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) track_byte(in_ch.data_byte, in_ch.is_aux);
  end

  always @(posedge clk) begin
    cursor_rpt_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_moves.size() == 0) begin
        note_failure($sformatf("unexpected result x=%0d y=%0d ev=%0d drop=%0d",
                               out_ch.cursor_x, out_ch.cursor_y,
                               out_ch.button_event, out_ch.packet_dropped));
      end else begin
        want = expected_moves.pop_front();
        if (out_ch.cursor_x !== want.x || out_ch.cursor_y !== want.y ||
            out_ch.button_event !== want.ev || out_ch.packet_dropped !== want.drop)
          note_failure($sformatf(
            "mismatch: expected x=%0d y=%0d ev=%0d drop=%0d, got x=%0d y=%0d ev=%0d drop=%0d",
            want.x, want.y, want.ev, want.drop, out_ch.cursor_x, out_ch.cursor_y,
            out_ch.button_event, out_ch.packet_dropped));
      end
    end
  end

  always @(posedge clk) begin
    rcv_tick <= rcv_tick + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rcv_mode)
        RCV_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        RCV_PATTERN: out_ch.ready <= RCV_MASK[rcv_tick % 7];
        RCV_SPARSE:  out_ch.ready <= ($urandom_range(0, 9) < 3);
        default:     out_ch.ready <= 1'b1;
      endcase
    end
  end

  task automatic send_item(input logic [7:0] b, input logic aux);
    if (gap_max > 0 && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.is_aux    <= aux;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] st, input logic [7:0] xd,
                             input logic [7:0] yd, input bit noisy);
    logic [7:0] bytes[3];
    bytes = '{st, xd, yd};
    foreach (bytes[i]) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(bytes[i], 1'b1);
    end
  endtask

  function automatic logic [7:0] rand_delta();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'($urandom_range(1, 8));
      2:       return 8'($urandom_range(248, 255));
      3:       return ($urandom_range(0, 1) != 0) ? 8'h7F : 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] rand_bound();
    case ($urandom_range(0, 7))
      0:       return CFG_BITS'($urandom_range(1, 4));
      1:       return CFG_BITS'($urandom_range(4090, 4096));
      2:       return CFG_BITS'($urandom_range(301, 4089));
      default: return CFG_BITS'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic rand_packet(input bit noisy);
    logic [7:0] st;
    st = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) != 0) st &= ~(X_OVF | Y_OVF);
    send_packet(st, rand_delta(), rand_delta(), noisy);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_moves.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic set_bounds(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    bound_w = w;
    bound_h = h;
    @(posedge clk);
  endtask

  task automatic test_startup_skip();
    gap_max  = 0;
    rcv_mode = RCV_ALWAYS;
    send_item(8'h08, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h09, 1'b1);
    send_packet(8'h00, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_packet_fields();
    gap_max  = 3;
    rcv_mode = RCV_PATTERN;
    send_packet(BTN_LEFT, 8'h7F, 8'h00, 1'b0);
    send_item(BTN_LEFT | BTN_RIGHT | Y_NEG, 1'b1);
    send_item(8'hAA, 1'b0);
    send_item(8'h01, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_packet(X_NEG | Y_NEG | BTN_RIGHT, 8'h00, 8'h00, 1'b0);
    send_packet(X_NEG, 8'h00, 8'h05, 1'b0);
    send_packet(X_OVF | BTN_RIGHT, 8'h10, 8'h10, 1'b0);
    send_packet(8'hFF, 8'h80, 8'h7F, 1'b0);
    send_packet(8'h0C, 8'hFF, 8'hFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_screen_bounds();
    gap_max  = 6;
    rcv_mode = RCV_RANDOM;
    set_bounds(CFG_BITS'(4096), CFG_BITS'(4096));
    repeat (34) send_packet(Y_NEG, 8'h7F, 8'h81, 1'b0);
    wait_idle();
    set_bounds(CFG_BITS'(100), CFG_BITS'(50));
    send_packet(X_NEG, 8'hFF, 8'h01, 1'b0);
    send_packet(Y_NEG, 8'h01, 8'hFF, 1'b0);
    repeat (10) rand_packet(1'b1);
    wait_idle();
    set_bounds(CFG_BITS'(1), CFG_BITS'(1));
    repeat (8) rand_packet(1'b0);
    wait_idle();
    set_bounds(CFG_BITS'(0), CFG_BITS'(8191));
    repeat (8) rand_packet(1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    gap_max  = 0;
    rcv_mode = RCV_ALWAYS;
    set_bounds(WIDTH_RST, HEIGHT_RST);
    hold_cycles <= 200;
    repeat (15) rand_packet(1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    repeat (4) begin
      set_bounds(rand_bound(), rand_bound());
      rcv_mode = $urandom_range(RCV_ALWAYS, RCV_SPARSE);
      gap_max  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      repeat (15) begin
        if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
        rand_packet(1'b1);
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_IDX_WIDTH;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.is_aux    = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup_skip();
    test_packet_fields();
    test_screen_bounds();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (expected_moves.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", expected_moves.size()));
    if (err_count == 0) begin
      $display("** ps2_mouse_packet_tracker_unit: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_tracker_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** ps2_mouse_packet_tracker_unit: FAILED **");
    $finish;
  end

endmodule
